FILE: hw/rtl/prq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_pkg
// Shared constants, codes and types for the priority ready queue.
// ----------------------------------------------------------------------------
package prq_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Field widths
  localparam int unsigned OpW    = 2;
  localparam int unsigned PrioW  = 4;
  localparam int unsigned TaskW  = 8;
  localparam int unsigned DelayW = 16;
  localparam int unsigned StatW  = 3;
  localparam int unsigned OccW   = 5;

  // Legal priority range
  localparam logic [PrioW-1:0] PrioMin = PrioW'(1);
  localparam logic [PrioW-1:0] PrioMax = PrioW'(8);

  // Operation codes
  localparam logic [OpW-1:0] OpEnqueue  = 2'd0;
  localparam logic [OpW-1:0] OpDispatch = 2'd1;
  localparam logic [OpW-1:0] OpRerun    = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] StOk      = 3'd0;
  localparam logic [StatW-1:0] StBadPrio = 3'd1;
  localparam logic [StatW-1:0] StFull    = 3'd2;
  localparam logic [StatW-1:0] StEmpty   = 3'd3;
  localparam logic [StatW-1:0] StParked  = 3'd4;

  // One queue entry
  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [TaskW-1:0] task_id;
  } prq_entry_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       insert;
    logic       pop;
    prq_entry_t new_entry;
  } prq_ctrl_t;

endpackage

FILE: hw/rtl/prq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_cell
// One slot of the shift-register queue: holds, takes the new entry, shifts
// from its left neighbor on insert, or from its right neighbor on pop.
// ----------------------------------------------------------------------------
module prq_cell
  import prq_pkg::*;
(
  input  logic       clk_i,
  input  prq_ctrl_t  ctrl_i,
  input  logic       occ_i,
  input  logic       left_keep_i,
  input  prq_entry_t left_i,
  input  prq_entry_t right_i,
  output logic       keep_o,
  output prq_entry_t entry_o
);

  prq_entry_t entry_q, entry_d;

  // Keep the slot when it holds an entry of equal or better priority
  assign keep_o = occ_i && (entry_q.prio <= ctrl_i.new_entry.prio);

  // Select the next slot contents
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.insert) begin
      if (keep_o) begin
        entry_d = entry_q;
      end else if (left_keep_i) begin
        entry_d = ctrl_i.new_entry;
      end else begin
        entry_d = left_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: hw/rtl/priority_ready_queue.sv
`timescale 1ns / 1ps
// A result word is valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is not stalled.
// The output register takes a new word whenever it is empty or being drained.
// Reset clears the entry count, the current task and the output valid;
// the slot contents are not cleared and are read only below the entry count.
// ----------------------------------------------------------------------------
// priority_ready_queue
// Stable priority ready queue built as a row of shifting cells.
// ----------------------------------------------------------------------------
module priority_ready_queue
  import prq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [OpW-1:0]    op_i,
  input  logic [PrioW-1:0]  priority_req_i,
  input  logic [TaskW-1:0]  task_id_i,
  input  logic [DelayW-1:0] rerun_delay_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StatW-1:0]  status_o,
  output logic [TaskW-1:0]  out_task_o,
  output logic [PrioW-1:0]  out_priority_o,
  output logic              dispatched_o,
  output logic [OccW-1:0]   occupancy_o
);

  logic [CntW-1:0]  count_q, count_d;
  prq_entry_t       cur_q, cur_d;
  logic             cur_valid_q, cur_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [StatW-1:0] status_q, status_d;
  logic [TaskW-1:0] otask_q, otask_d;
  logic [PrioW-1:0] oprio_q, oprio_d;
  logic             disp_q, disp_d;
  logic [OccW-1:0]  occ_q, occ_d;

  logic             accept;
  logic             full;
  prq_ctrl_t        ctrl;

  prq_entry_t       cell_entry [QueueDepth];
  logic             cell_keep  [QueueDepth];

  // Accept while the output register is empty or draining
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q >= CntW'(QueueDepth));

  // Decode the word into queue control and a result
  always_comb begin
    ctrl.insert    = 1'b0;
    ctrl.pop       = 1'b0;
    ctrl.new_entry = '{prio: priority_req_i, task_id: task_id_i};
    count_d        = count_q;
    cur_d          = cur_q;
    cur_valid_d    = cur_valid_q;
    status_d       = StOk;
    otask_d        = '0;
    oprio_d        = '0;
    disp_d         = 1'b0;
    case (op_i)
      OpEnqueue: begin
        if (priority_req_i < PrioMin || priority_req_i > PrioMax) begin
          status_d = StBadPrio;
        end else if (full) begin
          status_d = StFull;
        end else begin
          ctrl.insert = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      OpDispatch: begin
        if (count_q == '0) begin
          status_d = StEmpty;
        end else begin
          ctrl.pop    = accept;
          cur_d       = cell_entry[0];
          cur_valid_d = 1'b1;
          otask_d     = cell_entry[0].task_id;
          oprio_d     = cell_entry[0].prio;
          disp_d      = 1'b1;
          count_d     = count_q - CntW'(1);
        end
      end
      OpRerun: begin
        ctrl.new_entry = cur_q;
        if (!cur_valid_q) begin
          status_d = StEmpty;
        end else begin
          otask_d = cur_q.task_id;
          oprio_d = cur_q.prio;
          if (rerun_delay_i != '0) begin
            status_d = StParked;
          end else if (full) begin
            status_d = StFull;
          end else begin
            ctrl.insert = accept;
            count_d     = count_q + CntW'(1);
          end
        end
      end
      default: begin
        status_d = StOk;
      end
    endcase
  end

  // Occupancy after this word, masked to the port width
  assign occ_d = OccW'(count_d);

  // Row of cells; cell zero sees the new entry as its left neighbor
  for (genvar k = 0; k < QueueDepth; k++) begin : g_cell
    logic       occ;
    logic       lkeep;
    prq_entry_t left;
    prq_entry_t right;

    assign occ = (CntW'(k) < count_q);

    if (k == 0) begin : g_first
      assign lkeep = 1'b0;
      assign left  = ctrl.new_entry;
    end else begin : g_mid
      assign lkeep = cell_keep[k-1];
      assign left  = cell_entry[k-1];
    end

    if (k == QueueDepth - 1) begin : g_last
      assign right = cell_entry[k];
    end else begin : g_inner
      assign right = cell_entry[k+1];
    end

    prq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .left_keep_i (lkeep),
      .left_i      (left),
      .right_i     (right),
      .keep_o      (cell_keep[k]),
      .entry_o     (cell_entry[k])
    );
  end

  // Output valid: set on accept, clear when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_valid_q <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q     <= count_d;
        cur_valid_q <= cur_valid_d;
        cur_q       <= cur_d;
      end
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      otask_q  <= otask_d;
      oprio_q  <= oprio_d;
      disp_q   <= disp_d;
      occ_q    <= occ_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign out_task_o     = otask_q;
  assign out_priority_o = oprio_q;
  assign dispatched_o   = disp_q;
  assign occupancy_o    = occ_q;

endmodule

FILE: hw/rtl/prq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prq_checker
// Port-level checks on the result words of the priority ready queue.
// ----------------------------------------------------------------------------
module prq_checker
  import prq_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [StatW-1:0]  status_o,
  input logic [TaskW-1:0]  out_task_o,
  input logic [PrioW-1:0]  out_priority_o,
  input logic              dispatched_o,
  input logic [OccW-1:0]   occupancy_o
);

  // A dispatched word always reports success and a legal priority
  a_disp_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dispatched_o |->
      status_o == StOk && out_priority_o >= PrioMin && out_priority_o <= PrioMax)
    else $error("dispatch word with bad status or priority");

  // A rejected or empty word carries no task
  a_err_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StBadPrio || status_o == StEmpty) |->
      out_task_o == '0 && out_priority_o == '0 && !dispatched_o)
    else $error("error word carries a task");

  // A full report only comes with a full queue
  a_full_occ : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StFull |-> occupancy_o == OccW'(QueueDepth))
    else $error("full status while queue not full");

  // A stalled result word holds
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(status_o) && $stable(out_task_o) && $stable(occupancy_o))
    else $error("stalled result word changed");

endmodule

bind priority_ready_queue prq_checker u_prq_checker (.*);
